// File: hdl/ppm_pkg.sv
// ----------------------------------------------------------------------------
// PPM decoder package
// Opcodes, register indexes, sequencer states and fixed widths shared by the
// frame decoder and its divider.
// ----------------------------------------------------------------------------
package ppm_pkg;

  typedef enum logic [1:0] {
    OP_EDGE   = 2'd0,
    OP_SCALED = 2'd1,
    OP_RAW    = 2'd2,
    OP_NONE   = 2'd3
  } opcode_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RESULT,
    ST_MUL,
    ST_DIVGO,
    ST_DIVWAIT
  } seq_state_t;

  // Configuration register indexes.
  localparam logic [2:0] REG_SYNC_GAP  = 3'd0;
  localparam logic [2:0] REG_CAL_FIRST = 3'd1;
  localparam logic [2:0] REG_CAL_LAST  = 3'd6;

  localparam int CFG_IDX_W = 3;
  localparam int CFG_W     = 32;
  localparam int CAL_REGS  = 6;
  localparam int CAL_IW    = 3;
  localparam int CH_NUM_W  = 3;
  localparam int SLOT_W    = 3;
  localparam int TIME_W    = 32;
  localparam int WIDTH_W   = 16;
  localparam int VAL_W     = 16;

  localparam logic [15:0] SYNC_GAP_RESET = 16'd6000;
  localparam logic [31:0] CAL_RESET      = 32'd131073000;
  localparam int          SCALE_SPAN     = 180;

  // The scaled numerator magnitude is at most 65535 * 180, below 2^24.
  localparam int DVD_W = 24;
  localparam int DSR_W = 16;
  localparam int CNT_W = 5;

  localparam logic signed [VAL_W-1:0] SAT_MAX = 16'sh7FFF;
  localparam logic signed [VAL_W-1:0] SAT_MIN = 16'sh8000;

endpackage

// File: hdl/ppm_frame_decoder_with_channel_scaling.sv
// ----------------------------------------------------------------------------
// PPM frame decoder with channel scaling
// Measures edge intervals into slot widths and rescales all channels with a
// shared multiply stage and a serial divider when a scaled read finds a frame.
// ----------------------------------------------------------------------------
//  Channel  | Handshake                  | Payload
//  ---------+----------------------------+-----------------------------------
//  input    | in_valid / in_stall        | opcode, edge_time_us, channel
//  output   | out_valid / out_stall      | value
//  config   | cfg_write                  | cfg_index, cfg_data
//
// An edge item is taken in the idle state. A raw read, or a scaled read with
// no new frame, passes the result state plus any wait on the output register.
// A scaled read of a new frame rescales every channel first: per channel a
// multiply, a divider start, 24 divider steps and a store, or a store alone
// for a channel with equal bounds. The divider is the limit.
// Input stalls while any item is at work.
// Reset is synchronous; no clearing pass is needed.
// ----------------------------------------------------------------------------
module ppm_frame_decoder_with_channel_scaling #(
  parameter int NUM_CHANNELS = 6
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [1:0]                        opcode,
  input  logic [ppm_pkg::TIME_W-1:0]        edge_time_us,
  input  logic [ppm_pkg::CH_NUM_W-1:0]      channel,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [ppm_pkg::VAL_W-1:0]  value,
  input  logic                              cfg_write,
  input  logic [ppm_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [ppm_pkg::CFG_W-1:0]         cfg_data
);
  import ppm_pkg::*;

  localparam int CH_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

  seq_state_t state, state_next;

  logic [WIDTH_W-1:0]      sync_gap;
  logic [CFG_W-1:0]        cal [CAL_REGS];

  logic [TIME_W-1:0]       last_edge_time;
  logic [SLOT_W-1:0]       slot_count;
  logic [WIDTH_W-1:0]      raw_width [NUM_CHANNELS];
  logic signed [VAL_W-1:0] scaled_value [NUM_CHANNELS];
  logic                    frame_ready;

  opcode_t                 op_reg;
  logic [CH_NUM_W-1:0]     ch_reg;
  logic [CH_W-1:0]         idx;
  logic                    neg;
  logic [DVD_W-1:0]        num_mag;
  logic [DSR_W-1:0]        den_mag;

  logic                    in_accept;
  logic                    out_free;
  logic                    div_start;
  logic                    div_done;
  logic [DVD_W-1:0]        div_quo;

  logic [TIME_W-1:0]       interval;
  logic                    ch_ok;
  logic [CH_W-1:0]         rd_idx;
  logic [WIDTH_W-1:0]      raw_rd;
  logic [CFG_W-1:0]        cal_rd;
  logic [WIDTH_W-1:0]      lo, hi;
  logic signed [WIDTH_W:0] diff, den;
  logic signed [25:0]      prod;
  logic [DVD_W-1:0]        prod_mag;
  logic [DSR_W-1:0]        den_abs;
  logic                    last_ch;
  logic signed [VAL_W-1:0] sat_val;
  logic signed [VAL_W-1:0] result;

  assign in_accept = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;
  assign interval  = edge_time_us - last_edge_time;
  assign ch_ok     = (ch_reg != '0) && (ch_reg <= CH_NUM_W'(NUM_CHANNELS));
  assign last_ch   = (idx == CH_W'(NUM_CHANNELS - 1));

  // One read port per array: the rescale walk or the requested channel (cal follows the walk only).
  always_comb begin
    rd_idx = (state == ST_RESULT) ? CH_W'(ch_reg - 1'b1) : idx;
    raw_rd = raw_width[rd_idx];
    cal_rd = cal[CAL_IW'(idx)];
    lo     = cal_rd[15:0];
    hi     = cal_rd[31:16];
    diff   = $signed({1'b0, raw_rd}) - $signed({1'b0, lo});
    den    = $signed({1'b0, hi}) - $signed({1'b0, lo});
    prod   = diff * $signed(9'(SCALE_SPAN));
    prod_mag = prod[25] ? DVD_W'(-prod) : prod[DVD_W-1:0];
    den_abs  = den[WIDTH_W] ? DSR_W'(-den) : den[DSR_W-1:0];
  end

  // Truncating division of magnitudes, then the sign and saturation.
  always_comb begin
    if (!neg) begin
      sat_val = (div_quo > DVD_W'(32767)) ? SAT_MAX : $signed(div_quo[VAL_W-1:0]);
    end else begin
      sat_val = (div_quo > DVD_W'(32768)) ? SAT_MIN : -$signed(div_quo[VAL_W-1:0]);
    end
  end

  always_comb begin
    result = '0;
    if (ch_ok) begin
      if (op_reg == OP_RAW) begin
        result = raw_rd[WIDTH_W-1] ? SAT_MAX : $signed(raw_rd);
      end else begin
        result = scaled_value[rd_idx];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_stall   = 1'b1;
    div_start  = 1'b0;
    case (state)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          if (opcode == OP_RAW) begin
            state_next = ST_RESULT;
          end else if (opcode == OP_SCALED) begin
            state_next = frame_ready ? ST_MUL : ST_RESULT;
          end
        end
      end
      ST_MUL: begin
        if (den_abs == '0) begin
          state_next = last_ch ? ST_RESULT : ST_MUL;
        end else begin
          state_next = ST_DIVGO;
        end
      end
      ST_DIVGO: begin
        div_start  = 1'b1;
        state_next = ST_DIVWAIT;
      end
      ST_DIVWAIT: begin
        if (div_done) begin
          state_next = last_ch ? ST_RESULT : ST_MUL;
        end
      end
      ST_RESULT: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Control state: configuration, frame tracking, slot and scaled values and the output flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      sync_gap       <= SYNC_GAP_RESET;
      for (int i = 0; i < CAL_REGS; i++) begin
        cal[i] <= CAL_RESET;
      end
      last_edge_time <= '0;
      slot_count     <= '0;
      frame_ready    <= 1'b0;
      out_valid      <= 1'b0;
      idx            <= '0;
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        raw_width[i]    <= '0;
        scaled_value[i] <= '0;
      end
    end else begin
      if (cfg_write) begin
        if (cfg_index == REG_SYNC_GAP) begin
          sync_gap <= cfg_data[WIDTH_W-1:0];
        end else if (cfg_index >= REG_CAL_FIRST && cfg_index <= REG_CAL_LAST) begin
          cal[CAL_IW'(cfg_index - REG_CAL_FIRST)] <= cfg_data;
        end
      end

      if (in_accept && opcode == OP_EDGE) begin
        last_edge_time <= edge_time_us;
        if (interval > TIME_W'(sync_gap)) begin
          slot_count <= '0;
        end else if (slot_count < SLOT_W'(NUM_CHANNELS)) begin
          raw_width[slot_count[CH_W-1:0]] <= interval[WIDTH_W-1:0];
          slot_count <= slot_count + 1'b1;
          if (slot_count == SLOT_W'(NUM_CHANNELS - 1)) begin
            frame_ready <= 1'b1;
          end
        end
      end

      if (in_accept) begin
        idx <= '0;
      end

      // A channel with equal bounds scales to zero without the divider.
      if (state == ST_MUL && den_abs == '0) begin
        scaled_value[idx] <= '0;
        idx <= idx + 1'b1;
        if (last_ch) begin
          frame_ready <= 1'b0;
        end
      end

      if (state == ST_DIVWAIT && div_done) begin
        scaled_value[idx] <= sat_val;
        idx <= idx + 1'b1;
        if (last_ch) begin
          frame_ready <= 1'b0;
        end
      end

      if (state == ST_RESULT && out_free) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      op_reg <= opcode_t'(opcode);
      ch_reg <= channel;
    end
    if (state == ST_MUL) begin
      num_mag <= prod_mag;
      den_mag <= den_abs;
      neg     <= prod[25] ^ den[WIDTH_W];
    end
    if (state == ST_RESULT && out_free) begin
      value <= result;
    end
  end

  ppm_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (num_mag),
    .divisor  (den_mag),
    .done     (div_done),
    .quotient (div_quo)
  );

  assert property (@(posedge clk) disable iff (rst)
    div_done |-> state == ST_DIVWAIT)
    else $error("divider finished outside the wait state");

  assert property (@(posedge clk) disable iff (rst)
    slot_count <= SLOT_W'(NUM_CHANNELS))
    else $error("slot count ran past the channel count");

  assert property (@(posedge clk) disable iff (rst)
    (in_accept && opcode == OP_SCALED && frame_ready) |=> state == ST_MUL)
    else $error("scaled read of a ready frame did not start a rescale");

  assert property (@(posedge clk) disable iff (rst)
    (state == ST_RESULT && $past(state) != ST_RESULT && $past(state) != ST_IDLE)
      |-> !frame_ready)
    else $error("ready mark still set after a rescale");

  assert property (@(posedge clk) disable iff (rst)
    (state == ST_RESULT && out_free) |=> out_valid)
    else $error("finished read did not reach the output register");

endmodule

// File: hdl/ppm_div.sv
// ----------------------------------------------------------------------------
// PPM unsigned divider
// Restoring divider that produces one quotient bit per cycle.
// ----------------------------------------------------------------------------
module ppm_div (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [ppm_pkg::DVD_W-1:0]  dividend,
  input  logic [ppm_pkg::DSR_W-1:0]  divisor,
  output logic                       done,
  output logic [ppm_pkg::DVD_W-1:0]  quotient
);
  import ppm_pkg::*;

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [DSR_W-1:0] rem;
  logic [DVD_W-1:0] quo;
  logic [DSR_W-1:0] dsr;

  logic [DSR_W:0]   shifted;
  logic [DSR_W+1:0] trial;
  logic             ge;

  // The remainder stays below the divisor, so both arms fit DSR_W bits.
  always_comb begin
    shifted = {rem, quo[DVD_W-1]};
    trial   = {1'b0, shifted} - {2'b00, dsr};
    ge      = ~trial[DSR_W+1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(DVD_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
      dsr <= divisor;
    end else if (busy) begin
      rem <= ge ? trial[DSR_W-1:0] : shifted[DSR_W-1:0];
      quo <= {quo[DVD_W-2:0], ge};
    end
  end

  assign quotient = quo;

endmodule
